FILE: rtl/core/hsv_to_rgb_pixel_assert.svh
// Assertion macros shared by the pixel converter
`ifndef HSV_TO_RGB_PIXEL_ASSERT_SVH
`define HSV_TO_RGB_PIXEL_ASSERT_SVH

// a holds in a cycle -> b holds in the same cycle
`define HSV_ASSERT_SAME(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);

// a holds in a cycle -> b holds in the next cycle
`define HSV_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);

`endif

FILE: rtl/core/hsv2rgb_pkg.sv
package hsv2rgb_pkg;

    // pipeline depth: sector/clamp, s*m, v*t, divide by 15 and saturate
    localparam int NUM_STAGES = 4;

    // hue arithmetic, in units of 1/64 degree (3840 per sector of 60 degrees)
    localparam logic [15:0] HUE_WRAP    = 16'd23040;
    localparam logic [15:0] HUE_WRAP2   = 16'd46080;
    localparam logic [14:0] FALL_END    = 15'd15360;
    localparam logic [14:0] SECTOR_K    = 15'd3840;
    localparam logic [11:0] SECTOR_M    = 12'd3840;

    // per-channel hue offsets (n * 3840 for n = 5, 3, 1)
    localparam logic [15:0] RED_OFFSET   = 16'd19200;
    localparam logic [15:0] GREEN_OFFSET = 16'd11520;
    localparam logic [15:0] BLUE_OFFSET  = 16'd3840;

    // fractions over 65536
    localparam logic [16:0] FRAC_ONE = 17'd65536;

    // 65536 * 3840
    localparam logic [27:0] T_FULL = 28'd251658240;

    // floor(p / 15) = (p * 8739) >> 17 for p below 10082
    localparam logic [13:0] RECIP_15    = 14'd8739;
    localparam int          RECIP_SHIFT = 17;

    localparam logic [7:0] CHAN_MAX = 8'd255;

    typedef struct packed {
        logic [14:0] hue;
        logic [16:0] sat;
        logic [16:0] val;
    } hsv_pixel_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_pixel_t;

    // stage load enables and stage valid bits
    typedef struct packed {
        logic [NUM_STAGES-1:0] en;
        logic [NUM_STAGES-1:0] vld;
    } pipe_ctl_t;

endpackage

FILE: rtl/core/hsv2rgb_ctl.sv
module hsv2rgb_ctl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   hsv_valid,
    output logic                   hsv_stall,
    output logic                   rgb_valid,
    input  logic                   rgb_stall,
    output hsv2rgb_pkg::pipe_ctl_t ctl
);

    logic [hsv2rgb_pkg::NUM_STAGES-1:0] valid_reg;
    logic [hsv2rgb_pkg::NUM_STAGES-1:0] valid_next;
    logic [hsv2rgb_pkg::NUM_STAGES-1:0] en;

    // a stage loads when it is empty or its content moves on
    always_comb
    begin
        en[hsv2rgb_pkg::NUM_STAGES-1] = !valid_reg[hsv2rgb_pkg::NUM_STAGES-1] || !rgb_stall;
        for (int i = hsv2rgb_pkg::NUM_STAGES - 2; i >= 0; i--)
        begin
            en[i] = !valid_reg[i] || en[i+1];
        end
    end

    // valid bits travel with the data
    always_comb
    begin
        valid_next = valid_reg;
        if (en[0])
        begin
            valid_next[0] = hsv_valid;
        end
        for (int i = 1; i < hsv2rgb_pkg::NUM_STAGES; i++)
        begin
            if (en[i])
            begin
                valid_next[i] = valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign hsv_stall = !en[0];
    assign rgb_valid = valid_reg[hsv2rgb_pkg::NUM_STAGES-1];
    assign ctl.en    = en;
    assign ctl.vld   = valid_reg;

endmodule

FILE: rtl/core/hsv2rgb_chan.sv
module hsv2rgb_chan (
    input  logic                   clk,
    input  hsv2rgb_pkg::pipe_ctl_t ctl,
    input  logic [14:0]            hue,
    input  logic [16:0]            sat,
    input  logic [16:0]            val,
    input  logic [15:0]            sector_offset,
    output logic [7:0]             chan
);

    // stage 1: hue position within the six sectors and the clamp term
    logic [15:0] pos_sum;
    logic [15:0] pos_wrapped;
    logic [14:0] pos_k;
    logic [14:0] fall_k;
    logic [14:0] min_k;
    logic [11:0] m_next;
    logic [11:0] m_reg;
    logic [16:0] sat1_reg;
    logic [16:0] val1_reg;

    always_comb
    begin
        pos_sum = {1'b0, hue} + sector_offset;
        if (pos_sum >= hsv2rgb_pkg::HUE_WRAP2)
        begin
            pos_wrapped = pos_sum - hsv2rgb_pkg::HUE_WRAP2;
        end
        else if (pos_sum >= hsv2rgb_pkg::HUE_WRAP)
        begin
            pos_wrapped = pos_sum - hsv2rgb_pkg::HUE_WRAP;
        end
        else
        begin
            pos_wrapped = pos_sum;
        end
        pos_k  = pos_wrapped[14:0];
        fall_k = hsv2rgb_pkg::FALL_END - pos_k;
        min_k  = (pos_k < fall_k) ? pos_k : fall_k;
        if (pos_k >= hsv2rgb_pkg::FALL_END)
        begin
            m_next = '0;
        end
        else if (min_k > hsv2rgb_pkg::SECTOR_K)
        begin
            m_next = hsv2rgb_pkg::SECTOR_M;
        end
        else
        begin
            m_next = min_k[11:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en[0])
        begin
            m_reg    <= m_next;
            sat1_reg <= sat;
            val1_reg <= val;
        end
    end

    // stage 2: t = 65536*3840 - s*m
    logic [28:0] sm_prod;
    logic [27:0] t_next;
    logic [27:0] t_reg;
    logic [16:0] val2_reg;

    assign sm_prod = sat1_reg * m_reg;
    assign t_next  = hsv2rgb_pkg::T_FULL - sm_prod[27:0];

    always_ff @(posedge clk)
    begin
        if (ctl.en[1])
        begin
            t_reg    <= t_next;
            val2_reg <= val1_reg;
        end
    end

    // stage 3: v*t, keep the part above 2^32 (at most 3840)
    logic [44:0] vt_prod;
    logic [11:0] p_reg;

    assign vt_prod = val2_reg * t_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.en[2])
        begin
            p_reg <= vt_prod[43:32];
        end
    end

    // stage 4: divide by 15 through the reciprocal, cap at 255
    logic [25:0] q_prod;
    logic [8:0]  q;
    logic [7:0]  chan_next;
    logic [7:0]  chan_reg;

    always_comb
    begin
        q_prod    = p_reg * hsv2rgb_pkg::RECIP_15;
        q         = q_prod[hsv2rgb_pkg::RECIP_SHIFT +: 9];
        chan_next = q[8] ? hsv2rgb_pkg::CHAN_MAX : q[7:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en[3])
        begin
            chan_reg <= chan_next;
        end
    end

    assign chan = chan_reg;

endmodule

FILE: rtl/core/hsv_to_rgb_pixel.sv
// HSV to RGB pixel converter, four register stages.
// Throughput: one item per cycle while the output is not stalled.
// Backpressure fills bubbles: input stalls only when all four stages are full.
// Reset (rst_n low, asynchronous) clears the stage valid bits; data is not reset.
`include "hsv_to_rgb_pixel_assert.svh"

module hsv_to_rgb_pixel (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    hsv_valid,
    output logic                    hsv_stall,
    input  hsv2rgb_pkg::hsv_pixel_t hsv,
    output logic                    rgb_valid,
    input  logic                    rgb_stall,
    output hsv2rgb_pkg::rgb_pixel_t rgb
);

    hsv2rgb_pkg::pipe_ctl_t ctl;
    logic [16:0]            sat_clip;
    logic [16:0]            val_clip;
    logic [7:0]             red;
    logic [7:0]             green;
    logic [7:0]             blue;
    logic                   in_take;
    logic                   out_blocked;
    logic                   pre_last_moves;

    // saturation and value above 1.0 are clipped to 1.0
    assign sat_clip = (hsv.sat > hsv2rgb_pkg::FRAC_ONE) ? hsv2rgb_pkg::FRAC_ONE : hsv.sat;
    assign val_clip = (hsv.val > hsv2rgb_pkg::FRAC_ONE) ? hsv2rgb_pkg::FRAC_ONE : hsv.val;

    hsv2rgb_ctl u_ctl (
        .clk       (clk),
        .rst_n     (rst_n),
        .hsv_valid (hsv_valid),
        .hsv_stall (hsv_stall),
        .rgb_valid (rgb_valid),
        .rgb_stall (rgb_stall),
        .ctl       (ctl)
    );

    hsv2rgb_chan u_red (
        .clk           (clk),
        .ctl           (ctl),
        .hue           (hsv.hue),
        .sat           (sat_clip),
        .val           (val_clip),
        .sector_offset (hsv2rgb_pkg::RED_OFFSET),
        .chan          (red)
    );

    hsv2rgb_chan u_green (
        .clk           (clk),
        .ctl           (ctl),
        .hue           (hsv.hue),
        .sat           (sat_clip),
        .val           (val_clip),
        .sector_offset (hsv2rgb_pkg::GREEN_OFFSET),
        .chan          (green)
    );

    hsv2rgb_chan u_blue (
        .clk           (clk),
        .ctl           (ctl),
        .hue           (hsv.hue),
        .sat           (sat_clip),
        .val           (val_clip),
        .sector_offset (hsv2rgb_pkg::BLUE_OFFSET),
        .chan          (blue)
    );

    assign rgb.red   = red;
    assign rgb.green = green;
    assign rgb.blue  = blue;

    // handshake terms watched by the checks below
    assign in_take        = hsv_valid && !hsv_stall;
    assign out_blocked    = rgb_valid && rgb_stall;
    assign pre_last_moves = ctl.vld[hsv2rgb_pkg::NUM_STAGES-2] && !rgb_stall;

    // input pushback only when the output holds a blocked item
    `HSV_ASSERT_SAME(a_stall_cause, clk, rst_n, hsv_stall, out_blocked, "stall, output free")
    // an accepted item lands in the first stage
    `HSV_ASSERT_NEXT(a_first_load, clk, rst_n, in_take, ctl.vld[0], "item lost at entry")
    // a free output takes the item from the stage before it
    `HSV_ASSERT_NEXT(a_last_load, clk, rst_n, pre_last_moves, rgb_valid, "item lost at exit")

endmodule
